// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the sparse polynomial term table RTL.
// Define NO_ASSERTIONS to compile every assertion out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// A property that must hold at every clock edge outside reset.
`define SPT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// A condition that must be followed by a consequence in the next cycle.
`define SPT_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`else

`define SPT_ASSERT(lbl, clk, rst_n, prop)
`define SPT_ASSERT_NEXT(lbl, clk, rst_n, cond, cons)

`endif

`endif

// ----- rtl/core/spt_pkg.sv -----
// Package of the sparse polynomial term table: sizes, codes and shared types.
// No dependencies.
`default_nettype none

package spt_pkg;

    // Table size and derived index widths.
    localparam int MAX_TERMS = 16;
    localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);

    // Field widths.
    localparam int OP_W      = 2;
    localparam int IN_COEF_W = 32;
    localparam int IN_DEG_W  = 8;
    localparam int COEF_W    = 48;
    localparam int DEG_W     = 9;
    localparam int STATUS_W  = 3;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_DERIV  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_NEW      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MERGED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_STREAMED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    // Degree held by the former constant term after a derivative.
    localparam logic signed [DEG_W-1:0] DEG_NONE = '1;

    // Saturation bounds of a stored coefficient.
    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    // One stored term.
    typedef struct packed {
        logic signed [DEG_W-1:0]  deg;
        logic signed [COEF_W-1:0] coef;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // A clamped coefficient and its saturation flag.
    typedef struct packed {
        logic signed [COEF_W-1:0] coef;
        logic                     sat;
    } arith_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/spt_if.sv -----
// Request and result channel interfaces of the sparse polynomial term table.
// Depends on spt_pkg.
`default_nettype none

interface spt_item_if import spt_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [OP_W-1:0]             operation;
    logic signed [IN_COEF_W-1:0] coefficient;
    logic [IN_DEG_W-1:0]         degree;

    modport source (output valid, operation, coefficient, degree, input ready);
    modport sink (input valid, operation, coefficient, degree, output ready);
endinterface

interface spt_result_if import spt_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [COEF_W-1:0]   term_coefficient;
    logic signed [DEG_W-1:0]    term_degree;
    logic [STATUS_W-1:0]        status;
    logic                       last;
    logic                       saturated;

    modport source (output valid, term_coefficient, term_degree, status, last, saturated,
                    input ready);
    modport sink (input valid, term_coefficient, term_degree, status, last, saturated,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sparse_polynomial_term_table_top.sv -----
// A new term is found by a scan of the table; the terms below its place are moved down one
// entry each and then it is written. A merge or a drop follows the scan. A read-out or a
// derivative first reads the last term, then streams each term through S_TERM and S_EMIT; an
// empty read-out or a clear reports through S_EMPTY. A result that waits stalls the controller.
// Throughput: one request at a time, as the term memory is walked one entry per step.
// Reset clears the count and control state only; entries at or above the count are never read.
`default_nettype none
`include "assert_macros.svh"

module sparse_polynomial_term_table_top import spt_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    spt_item_if.sink    item,
    spt_result_if.source result
);

    // Controller states.
    localparam int SW = 4;
    localparam logic [SW-1:0] S_IDLE    = 4'd0;
    localparam logic [SW-1:0] S_SRCH    = 4'd1;
    localparam logic [SW-1:0] S_MERGE   = 4'd2;
    localparam logic [SW-1:0] S_INS_CHK = 4'd3;
    localparam logic [SW-1:0] S_SHIFT   = 4'd4;
    localparam logic [SW-1:0] S_INS_WR  = 4'd5;
    localparam logic [SW-1:0] S_TAIL    = 4'd6;
    localparam logic [SW-1:0] S_TERM    = 4'd7;
    localparam logic [SW-1:0] S_EMIT    = 4'd8;
    localparam logic [SW-1:0] S_EMPTY   = 4'd9;

    logic [SW-1:0]    state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] pos_reg, pos_next;

    // Latched request.
    logic [OP_W-1:0]             op_reg;
    logic signed [IN_COEF_W-1:0] coef_reg;
    logic [IN_DEG_W-1:0]         deg_reg;

    // Result register.
    logic                     out_valid_reg;
    logic signed [COEF_W-1:0] out_coef_reg;
    logic signed [DEG_W-1:0]  out_deg_reg;
    logic [STATUS_W-1:0]      out_status_reg;
    logic                     out_last_reg;
    logic                     out_sat_reg;

    logic                     out_free;
    logic                     out_load;
    logic signed [COEF_W-1:0] ld_coef;
    logic signed [DEG_W-1:0]  ld_deg;
    logic [STATUS_W-1:0]      ld_status;
    logic                     ld_last;
    logic                     ld_sat;

    // Memory port signals.
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_entry;

    logic       prod_load;
    arith_res_t merge_res;
    arith_res_t deriv_res;

    logic                     item_fire;
    logic signed [DEG_W-1:0]  ins_deg;
    logic signed [COEF_W-1:0] ins_coef;
    logic [IDX_W-1:0]         idx_inc;
    logic [IDX_W-1:0]         idx_dec;
    logic [CNT_W-1:0]         idx_ext;
    logic                     idx_is_last;
    logic [CNT_W-1:0]         eff_count;

    // Term memory.
    spt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TERMS)
    ) u_term_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);

    // Coefficient arithmetic.
    spt_alu u_alu (
        .clk       (clk),
        .stored    (rd_entry),
        .add_coef  (coef_reg),
        .prod_load (prod_load),
        .merge_res (merge_res),
        .deriv_res (deriv_res)
    );

    // Handshake and helper values.
    assign item.ready  = (state_reg == S_IDLE);
    assign item_fire   = item.valid && item.ready;
    assign out_free    = !out_valid_reg || result.ready;
    assign ins_deg     = $signed({1'b0, deg_reg});
    assign ins_coef    = {{(COEF_W-IN_COEF_W){coef_reg[IN_COEF_W-1]}}, coef_reg};
    assign idx_inc     = idx_reg + IDX_W'(1);
    assign idx_dec     = idx_reg - IDX_W'(1);
    assign idx_ext     = CNT_W'(idx_reg);
    assign idx_is_last = (CNT_W'(idx_ext + CNT_W'(1)) == count_reg);
    assign eff_count   = (op_reg == OP_DERIV && rd_entry.deg == DEG_NONE)
                       ? CNT_W'(count_reg - CNT_W'(1)) : count_reg;

    // Controller: scans, shifts and streams the term memory one entry per step.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = rd_entry;
        ram_re     = 1'b0;
        ram_raddr  = idx_reg;
        prod_load  = 1'b0;
        out_load   = 1'b0;
        ld_coef    = '0;
        ld_deg     = '0;
        ld_status  = ST_EMPTY;
        ld_last    = 1'b1;
        ld_sat     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_fire)
                begin
                    unique case (item.operation) inside
                        OP_INSERT:
                        begin
                            idx_next = '0;
                            if (count_reg == '0)
                            begin
                                pos_next   = '0;
                                state_next = S_INS_CHK;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                state_next = S_SRCH;
                            end
                        end
                        OP_READ, OP_DERIV:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = S_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = IDX_W'(count_reg - CNT_W'(1));
                                state_next = S_TAIL;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_EMPTY;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Walk up the table until a degree at or below the new one.
            S_SRCH:
            begin
                if (rd_entry.deg <= ins_deg)
                begin
                    if (rd_entry.deg == ins_deg)
                    begin
                        state_next = S_MERGE;
                    end
                    else
                    begin
                        pos_next   = idx_ext;
                        state_next = S_INS_CHK;
                    end
                end
                else if (idx_is_last)
                begin
                    pos_next   = count_reg;
                    state_next = S_INS_CHK;
                end
                else
                begin
                    idx_next  = idx_inc;
                    ram_re    = 1'b1;
                    ram_raddr = idx_inc;
                end
            end

            // Add into the matching term and write it back.
            S_MERGE:
            begin
                if (out_free)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = idx_reg;
                    ram_wdata.deg  = rd_entry.deg;
                    ram_wdata.coef = merge_res.coef;
                    out_load       = 1'b1;
                    ld_coef        = merge_res.coef;
                    ld_deg         = rd_entry.deg;
                    ld_status      = ST_MERGED;
                    ld_sat         = merge_res.sat;
                    state_next     = S_IDLE;
                end
            end

            // New degree: drop it when full, otherwise open a gap at its place unless it goes last.
            S_INS_CHK:
            begin
                if (count_reg == CNT_W'(MAX_TERMS))
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        ld_coef    = ins_coef;
                        ld_deg     = ins_deg;
                        ld_status  = ST_DROPPED;
                        state_next = S_IDLE;
                    end
                end
                else if (pos_reg == count_reg)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    idx_next   = IDX_W'(count_reg - CNT_W'(1));
                    ram_re     = 1'b1;
                    ram_raddr  = IDX_W'(count_reg - CNT_W'(1));
                    state_next = S_SHIFT;
                end
            end

            // Move one term down a place; the read runs one entry ahead.
            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_inc;
                ram_wdata = rd_entry;
                if (idx_ext == pos_reg)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    idx_next  = idx_dec;
                    ram_re    = 1'b1;
                    ram_raddr = idx_dec;
                end
            end

            S_INS_WR:
            begin
                if (out_free)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = IDX_W'(pos_reg);
                    ram_wdata.deg  = ins_deg;
                    ram_wdata.coef = ins_coef;
                    count_next     = CNT_W'(count_reg + CNT_W'(1));
                    out_load       = 1'b1;
                    ld_coef        = ins_coef;
                    ld_deg         = ins_deg;
                    ld_status      = ST_NEW;
                    state_next     = S_IDLE;
                end
            end

            // The last term tells whether a derivative drops a spent constant.
            S_TAIL:
            begin
                count_next = eff_count;
                if (eff_count == '0)
                begin
                    state_next = S_EMPTY;
                end
                else
                begin
                    idx_next   = '0;
                    ram_re     = 1'b1;
                    ram_raddr  = '0;
                    state_next = S_TERM;
                end
            end

            S_TERM:
            begin
                prod_load  = 1'b1;
                state_next = S_EMIT;
            end

            // Stream one term, rewriting it in place for a derivative.
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    ld_status = ST_STREAMED;
                    ld_last   = idx_is_last;
                    if (op_reg == OP_DERIV)
                    begin
                        ram_we         = 1'b1;
                        ram_waddr      = idx_reg;
                        ram_wdata.deg  = rd_entry.deg - DEG_W'(1);
                        ram_wdata.coef = deriv_res.coef;
                        ld_coef        = deriv_res.coef;
                        ld_deg         = rd_entry.deg - DEG_W'(1);
                        ld_sat         = deriv_res.sat;
                    end
                    else
                    begin
                        ld_coef = rd_entry.coef;
                        ld_deg  = rd_entry.deg;
                    end
                    if (idx_is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        ram_re     = 1'b1;
                        ram_raddr  = idx_inc;
                        state_next = S_TERM;
                    end
                end
            end

            S_EMPTY:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            op_reg   <= item.operation;
            coef_reg <= item.coefficient;
            deg_reg  <= item.degree;
        end
        if (out_load)
        begin
            out_coef_reg   <= ld_coef;
            out_deg_reg    <= ld_deg;
            out_status_reg <= ld_status;
            out_last_reg   <= ld_last;
            out_sat_reg    <= ld_sat;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.term_coefficient = out_coef_reg;
    assign result.term_degree      = out_deg_reg;
    assign result.status           = out_status_reg;
    assign result.last             = out_last_reg;
    assign result.saturated        = out_sat_reg;

    // Checks on the controller.
    `SPT_ASSERT(a_count_in_range, clk, rst_n, count_reg <= CNT_W'(MAX_TERMS))
    `SPT_ASSERT_NEXT(a_clear_empties, clk, rst_n, item_fire && item.operation == OP_CLEAR, count_reg == '0)
    `SPT_ASSERT(a_no_write_when_idle, clk, rst_n, !(ram_we && state_reg == S_IDLE))
    `SPT_ASSERT(a_load_only_when_free, clk, rst_n, !out_load || out_free)

endmodule

`default_nettype wire

// ----- rtl/core/spt_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module spt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/spt_alu.sv -----
// Coefficient arithmetic: saturating merge sum and registered derivative product.
// Depends on spt_pkg.
`default_nettype none

module spt_alu import spt_pkg::*; (
    input  wire logic                        clk,
    input  wire entry_t                      stored,
    input  wire logic signed [IN_COEF_W-1:0] add_coef,
    input  wire logic                        prod_load,
    output arith_res_t                       merge_res,
    output arith_res_t                       deriv_res
);

    localparam int PROD_W = COEF_W + DEG_W;

    localparam logic signed [PROD_W-1:0] P_MAX = {{DEG_W{1'b0}}, COEF_MAX};
    localparam logic signed [PROD_W-1:0] P_MIN = {{DEG_W{1'b1}}, COEF_MIN};

    logic signed [COEF_W:0]   sum;
    logic signed [PROD_W-1:0] sum_ext;
    logic signed [PROD_W-1:0] prod_reg;

    // Clamp a wide value to the stored coefficient range.
    function automatic arith_res_t sat48(input logic signed [PROD_W-1:0] v);
        arith_res_t r;
        if (v > P_MAX)
        begin
            r.coef = COEF_MAX;
            r.sat  = 1'b1;
        end
        else if (v < P_MIN)
        begin
            r.coef = COEF_MIN;
            r.sat  = 1'b1;
        end
        else
        begin
            r.coef = v[COEF_W-1:0];
            r.sat  = 1'b0;
        end
        return r;
    endfunction

    // Merge: stored coefficient plus the requested one.
    assign sum = {stored.coef[COEF_W-1], stored.coef}
               + {{(COEF_W+1-IN_COEF_W){add_coef[IN_COEF_W-1]}}, add_coef};
    assign sum_ext   = {{(PROD_W-COEF_W-1){sum[COEF_W]}}, sum};
    assign merge_res = sat48(sum_ext);

    // Derivative: coefficient times degree, registered before the clamp.
    always_ff @(posedge clk)
    begin
        if (prod_load)
        begin
            prod_reg <= $signed({{DEG_W{stored.coef[COEF_W-1]}}, stored.coef})
                      * $signed({{COEF_W{stored.deg[DEG_W-1]}}, stored.deg});
        end
    end

    assign deriv_res = sat48(prod_reg);

endmodule

`default_nettype wire

// ----- verif/tb_sparse_polynomial_term_table_top.sv -----
// Testbench of the sparse polynomial term table: a directed list and random request
// sequences, checked against a term-table predictor. Depends on spt_pkg, spt_if and
// sparse_polynomial_term_table_top.
module tb_sparse_polynomial_term_table_top;
    import spt_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_COUNT = 235;

    // One request as the driver offers it.
    typedef struct {
        logic [OP_W-1:0]             op;
        logic signed [IN_COEF_W-1:0] coef;
        logic [IN_DEG_W-1:0]         deg;
    } request_t;

    // One term result as the block should report it.
    typedef struct {
        logic signed [COEF_W-1:0] coef;
        logic signed [DEG_W-1:0]  deg;
        logic [STATUS_W-1:0]      status;
        logic                     last;
        logic                     sat;
    } term_result_t;

    logic clk = 1'b0;
    logic rst_n;

    spt_item_if   item_ch ();
    spt_result_if result_ch ();

    sparse_polynomial_term_table_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // Predicted contents of the term table.
    logic signed [DEG_W-1:0]  table_degree [MAX_TERMS];
    logic signed [COEF_W-1:0] table_coef   [MAX_TERMS];
    int                       table_count;

    request_t     request_queue [$];
    term_result_t results_due [$];

    bit request_offered;
    int send_wait;
    int send_calm;
    int recv_wait;
    int recv_calm;
    int quiet_cycles;
    int mismatches;
    int requests_sent;
    int results_seen;
    int saturated_seen;
    int status_seen [8];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Number of idle cycles before the next request or result, with calm stretches.
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    // Clamp a wide sum or product to the stored coefficient range.
    function automatic logic signed [COEF_W-1:0] clamp_coef(input longint v, output logic sat);
        longint hi;
        longint lo;
        hi = longint'(COEF_MAX);
        lo = longint'(COEF_MIN);
        sat = 1'b0;
        if (v > hi)
        begin
            sat = 1'b1;
            return COEF_MAX;
        end
        if (v < lo)
        begin
            sat = 1'b1;
            return COEF_MIN;
        end
        return v[COEF_W-1:0];
    endfunction

    function automatic void push_term(input logic signed [COEF_W-1:0] coef,
                                      input logic signed [DEG_W-1:0] deg,
                                      input logic [STATUS_W-1:0] status,
                                      input logic last, input logic sat);
        term_result_t t;
        t.coef   = coef;
        t.deg    = deg;
        t.status = status;
        t.last   = last;
        t.sat    = sat;
        results_due.push_back(t);
    endfunction

    // Apply one accepted request to the predicted table and queue its results.
    function automatic void apply_request(input request_t r);
        int                       pos;
        int                       keep;
        int                       w;
        logic                     sat;
        logic signed [DEG_W-1:0]  d;
        logic signed [COEF_W-1:0] c;
        d = $signed({1'b0, r.deg});
        case (r.op)
            OP_INSERT:
            begin
                pos = 0;
                while (pos < table_count && table_degree[pos] > d)
                    pos++;
                if (pos < table_count && table_degree[pos] == d)
                begin
                    table_coef[pos] = clamp_coef(longint'(table_coef[pos]) + longint'(r.coef),
                                                 sat);
                    push_term(table_coef[pos], d, ST_MERGED, 1'b1, sat);
                end
                else if (table_count >= MAX_TERMS)
                begin
                    c = COEF_W'(r.coef);
                    push_term(c, d, ST_DROPPED, 1'b1, 1'b0);
                end
                else
                begin
                    for (int i = table_count; i > pos; i--)
                    begin
                        table_degree[i] = table_degree[i-1];
                        table_coef[i]   = table_coef[i-1];
                    end
                    table_degree[pos] = d;
                    table_coef[pos]   = COEF_W'(r.coef);
                    table_count++;
                    push_term(table_coef[pos], d, ST_NEW, 1'b1, 1'b0);
                end
            end
            OP_READ:
            begin
                if (table_count == 0)
                    push_term('0, '0, ST_EMPTY, 1'b1, 1'b0);
                for (int i = 0; i < table_count; i++)
                    push_term(table_coef[i], table_degree[i], ST_STREAMED,
                              i == table_count - 1, 1'b0);
            end
            OP_DERIV:
            begin
                // A term already at degree minus one disappears.
                keep = 0;
                for (int i = 0; i < table_count; i++)
                    if (table_degree[i] != DEG_NONE)
                        keep++;
                w = 0;
                for (int i = 0; i < table_count; i++)
                begin
                    if (table_degree[i] != DEG_NONE)
                    begin
                        table_coef[w] = clamp_coef(longint'(table_coef[i]) *
                                                   longint'(table_degree[i]), sat);
                        table_degree[w] = table_degree[i] - 9'sd1;
                        push_term(table_coef[w], table_degree[w], ST_STREAMED,
                                  w == keep - 1, sat);
                        w++;
                    end
                end
                table_count = w;
                if (w == 0)
                    push_term('0, '0, ST_EMPTY, 1'b1, 1'b0);
            end
            default:
            begin
                table_count = 0;
                push_term('0, '0, ST_EMPTY, 1'b1, 1'b0);
            end
        endcase
    endfunction

    // Request driver: offers queued requests with a random gap after each one.
    always @(posedge clk)
    begin
        request_t r;
        if (!rst_n)
        begin
            item_ch.valid   <= 1'b0;
            request_offered = 1'b0;
            send_wait       = $urandom_range(0, 9);
            table_count     = 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                r.op   = item_ch.operation;
                r.coef = item_ch.coefficient;
                r.deg  = item_ch.degree;
                apply_request(r);
                requests_sent++;
                request_offered = 1'b0;
                send_wait = draw_gap(send_calm);
            end
            if (!request_offered)
            begin
                if (send_wait > 0)
                    send_wait--;
                else if (request_queue.size() > 0)
                begin
                    r = request_queue.pop_front();
                    item_ch.operation   <= r.op;
                    item_ch.coefficient <= r.coef;
                    item_ch.degree      <= r.deg;
                    request_offered = 1'b1;
                end
            end
            item_ch.valid <= request_offered;
        end
    end

    // Result monitor: checks every accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        term_result_t t;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            recv_wait = $urandom_range(0, 9);
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result: coef %0d deg %0d status %0d",
                                 result_ch.term_coefficient, result_ch.term_degree,
                                 result_ch.status);
                end
                else
                begin
                    t = results_due.pop_front();
                    status_seen[t.status]++;
                    if (t.sat)
                        saturated_seen++;
                    if (result_ch.term_coefficient !== t.coef ||
                        result_ch.term_degree !== t.deg ||
                        result_ch.status !== t.status ||
                        result_ch.last !== t.last ||
                        result_ch.saturated !== t.sat)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("Mismatch, expected coef %0d deg %0d status %0d last %0b sat %0b",
                                     t.coef, t.deg, t.status, t.last, t.sat);
                            $display("           actual coef %0d deg %0d status %0d last %0b sat %0b",
                                     result_ch.term_coefficient, result_ch.term_degree,
                                     result_ch.status, result_ch.last, result_ch.saturated);
                        end
                    end
                end
                recv_wait = draw_gap(recv_calm);
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Watchdog on cycles in which neither channel moves anything.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout after %0d idle cycles", quiet_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    task automatic queue_request(input logic [OP_W-1:0] op,
                                 input logic signed [IN_COEF_W-1:0] coef,
                                 input int deg);
        request_t r;
        r.op   = op;
        r.coef = coef;
        r.deg  = IN_DEG_W'(deg);
        request_queue.push_back(r);
    endtask

    // Coefficients lean towards the extremes and small values.
    function automatic logic signed [IN_COEF_W-1:0] pick_coefficient();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed(32'($urandom_range(0, 20))) - 32'sd10;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    // Stimulus: the directed list first, then random request sequences.
    initial
    begin
        int kind;
        int n;
        int base;
        int span;
        int total;
        item_ch.valid       = 1'b0;
        item_ch.operation   = OP_INSERT;
        item_ch.coefficient = '0;
        item_ch.degree      = '0;
        result_ch.ready     = 1'b0;
        rst_n               = 1'b0;

        // Operations on an empty table.
        queue_request(OP_READ, 0, 0);
        queue_request(OP_DERIV, 0, 0);
        queue_request(OP_CLEAR, 0, 0);
        // Extreme coefficients and degrees, a merge and a merge that sums to zero.
        queue_request(OP_INSERT, 32'sh7FFF_FFFF, 255);
        queue_request(OP_INSERT, 32'sh8000_0000, 0);
        queue_request(OP_INSERT, 1, 0);
        queue_request(OP_INSERT, 5, 100);
        queue_request(OP_INSERT, -5, 100);
        queue_request(OP_READ, 0, 0);
        // The constant term falls to degree minus one, then is removed; the top term saturates.
        queue_request(OP_DERIV, 0, 0);
        queue_request(OP_DERIV, 0, 0);
        queue_request(OP_DERIV, 0, 0);
        queue_request(OP_INSERT, 32'sh7FFF_FFFF, 252);
        queue_request(OP_READ, 0, 0);
        queue_request(OP_CLEAR, 0, 0);
        // Saturation towards the negative bound, by product and then by merge.
        queue_request(OP_INSERT, 32'sh8000_0000, 255);
        queue_request(OP_DERIV, 0, 0);
        queue_request(OP_DERIV, 0, 0);
        queue_request(OP_DERIV, 0, 0);
        queue_request(OP_INSERT, 32'sh8000_0000, 252);
        queue_request(OP_CLEAR, 0, 0);
        // A derivative that removes every term leaves an empty table.
        queue_request(OP_INSERT, 3, 0);
        queue_request(OP_DERIV, 0, 0);
        queue_request(OP_DERIV, 0, 0);
        queue_request(OP_READ, 0, 0);

        // Random sequences: mostly insert bursts followed by read-outs or derivatives.
        total = request_queue.size() + RANDOM_COUNT;
        while (request_queue.size() < total)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                n = $urandom_range(1, 20);
                if ($urandom_range(0, 1) == 0)
                begin
                    base = 0;
                    span = 255;
                end
                else
                begin
                    base = $urandom_range(0, 250);
                    span = 5;
                end
                for (int i = 0; i < n; i++)
                    queue_request(OP_INSERT, pick_coefficient(),
                                  base + $urandom_range(0, span));
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    queue_request($urandom_range(0, 1) ? OP_READ : OP_DERIV, 0, 0);
            end
            else if (kind == 6)
                queue_request(OP_CLEAR, 0, 0);
            else if (kind == 7)
                queue_request(OP_W'($urandom_range(0, 3)), $urandom, $urandom_range(0, 255));
            else if (kind == 8)
            begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    queue_request(OP_INSERT, $urandom, $urandom_range(0, 255));
                queue_request(OP_CLEAR, 0, 0);
            end
            else
            begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    queue_request(OP_DERIV, 0, 0);
                queue_request(OP_READ, 0, 0);
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all requests taken and every predicted result seen.
        @(negedge clk);
        while (request_queue.size() > 0 || request_offered || results_due.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d requests and %0d results: %0d new, %0d merged, %0d dropped,",
                 requests_sent, results_seen, status_seen[ST_NEW], status_seen[ST_MERGED],
                 status_seen[ST_DROPPED]);
        $display("%0d streamed, %0d empty; %0d saturated; %0d mismatches.",
                 status_seen[ST_STREAMED], status_seen[ST_EMPTY], saturated_seen, mismatches);
        if (mismatches == 0 && results_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/spt_pkg.sv
rtl/core/spt_if.sv
rtl/core/spt_ram.sv
rtl/core/spt_alu.sv
rtl/core/sparse_polynomial_term_table_top.sv
verif/tb_sparse_polynomial_term_table_top.sv
